[design/swsd_pkg.sv]
// ----------------------------------------------------------------------------
// swsd_pkg
// Shared types and constants of the sensor warm-up stability detector.
// ----------------------------------------------------------------------------
`default_nettype none

package swsd_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int WINDOW_LEN = 10;
  localparam int WIN_IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [WIN_IDX_W-1:0] WIN_LAST = WIN_IDX_W'(WINDOW_LEN - 1);

  localparam int CFG_IDX_W = 2;

  localparam logic [SAMPLE_W-1:0] GAS_THRESHOLD_RST = SAMPLE_W'(1500);
  localparam logic [SAMPLE_W-1:0] STAB_TOL_RST      = SAMPLE_W'(15);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAS_THRESHOLD = 2'd0,
    REG_STAB_TOL      = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic vld;
    logic first;
  } scan_ctl_t;

endpackage

`default_nettype wire

[design/swsd_ram.sv]
// ----------------------------------------------------------------------------
// swsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

[design/swsd_minmax.sv]
// ----------------------------------------------------------------------------
// swsd_minmax
// Shared compare unit: folds one window word per cycle into min and max.
// ----------------------------------------------------------------------------
`default_nettype none

module swsd_minmax (
  input  wire logic                         clk,
  input  wire swsd_pkg::scan_ctl_t          ctl,
  input  wire logic [swsd_pkg::SAMPLE_W-1:0] dat,
  output logic      [swsd_pkg::SAMPLE_W-1:0] lo,
  output logic      [swsd_pkg::SAMPLE_W-1:0] hi
);

  import swsd_pkg::*;

  logic [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic [SAMPLE_W-1:0] hi_r, hi_nxt;

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (ctl.vld) begin
      if (ctl.first) begin
        lo_nxt = dat;
        hi_nxt = dat;
      end else begin
        if (dat < lo_r) lo_nxt = dat;
        if (dat > hi_r) hi_nxt = dat;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign lo = lo_r;
  assign hi = hi_r;

endmodule

`default_nettype wire

[design/sensor_warmup_stability_detector_unit.sv]
// ----------------------------------------------------------------------------
// sensor_warmup_stability_detector_unit
// Ring of recent sensor samples, min/max scan and sticky stable flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | input     | valid / stall    | sample
//  out_    | output    | valid / stall    | over_threshold, stable, spread, flag
//  cfg_    | input     | valid / ready    | index, data
//
//  A word that needs no scan goes straight to the finish state; a scan word
//  steps through scan, tail and eval, with the RAM read giving one word per
//  cycle to the shared min/max compare unit. The input stalls until the
//  result is loaded into the output register. Reset clears the ring fill
//  state and the stable flag; the ring RAM itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_warmup_stability_detector_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [swsd_pkg::SAMPLE_W-1:0]       in_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_over_threshold,
  output logic                                     out_stable,
  output logic      [swsd_pkg::SAMPLE_W-1:0]       out_window_spread,
  output logic                                     out_spread_valid,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [swsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [swsd_pkg::SAMPLE_W-1:0]       cfg_data
);

  import swsd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_TAIL   = 5'b00100,
    ST_EVAL   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0]  thr_r, thr_nxt;
  logic [SAMPLE_W-1:0]  tol_r, tol_nxt;
  logic [WIN_IDX_W-1:0] slot_r, slot_nxt;
  logic                 filled_r, filled_nxt;
  logic                 stab_r, stab_nxt;
  logic [WIN_IDX_W-1:0] rd_cnt_r, rd_cnt_nxt;
  scan_ctl_t            ctl_r, ctl_nxt;

  logic                 ovr_r, ovr_nxt;
  logic [SAMPLE_W-1:0]  spread_r, spread_nxt;
  logic                 svld_r, svld_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 o_ovr_r, o_ovr_nxt;
  logic                 o_stab_r, o_stab_nxt;
  logic [SAMPLE_W-1:0]  o_spread_r, o_spread_nxt;
  logic                 o_svld_r, o_svld_nxt;

  logic                 in_acc;
  logic                 ram_we;
  logic                 ram_re;
  logic [SAMPLE_W-1:0]  ram_rdata;
  logic [SAMPLE_W-1:0]  win_lo;
  logic [SAMPLE_W-1:0]  win_hi;
  logic [SAMPLE_W-1:0]  diff;
  logic                 load_out;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign ram_we    = in_acc && !stab_r;
  assign ram_re    = (state_r == ST_SCAN);
  assign diff      = win_hi - win_lo;
  assign load_out  = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  swsd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (in_sample),
    .re    (ram_re),
    .raddr (rd_cnt_r),
    .rdata (ram_rdata)
  );

  swsd_minmax u_minmax (
    .clk (clk),
    .ctl (ctl_r),
    .dat (ram_rdata),
    .lo  (win_lo),
    .hi  (win_hi)
  );

  // configuration
  always_comb begin
    thr_nxt = thr_r;
    tol_nxt = tol_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAS_THRESHOLD: thr_nxt = cfg_data;
        REG_STAB_TOL:      tol_nxt = cfg_data;
        default:           ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    filled_nxt = filled_r;
    stab_nxt   = stab_r;
    rd_cnt_nxt = rd_cnt_r;
    ctl_nxt    = '0;
    ovr_nxt    = ovr_r;
    spread_nxt = spread_r;
    svld_nxt   = svld_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ovr_nxt    = (in_sample > thr_r);
          spread_nxt = '0;
          svld_nxt   = 1'b0;
          rd_cnt_nxt = '0;
          state_nxt  = ST_FINISH;
          if (!stab_r) begin
            if (slot_r == WIN_LAST) begin
              slot_nxt   = '0;
              filled_nxt = 1'b1;
            end else begin
              slot_nxt = slot_r + 1'b1;
            end
            if (filled_r || slot_r == WIN_LAST) begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        ctl_nxt.vld   = 1'b1;
        ctl_nxt.first = (rd_cnt_r == '0);
        if (rd_cnt_r == WIN_LAST) begin
          state_nxt = ST_TAIL;
        end else begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        spread_nxt = diff;
        svld_nxt   = 1'b1;
        if (diff <= tol_r) begin
          stab_nxt = 1'b1;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    o_ovr_nxt     = o_ovr_r;
    o_stab_nxt    = o_stab_r;
    o_spread_nxt  = o_spread_r;
    o_svld_nxt    = o_svld_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      o_ovr_nxt     = ovr_r;
      o_stab_nxt    = stab_r;
      o_spread_nxt  = spread_r;
      o_svld_nxt    = svld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= GAS_THRESHOLD_RST;
      tol_r       <= STAB_TOL_RST;
      slot_r      <= '0;
      filled_r    <= 1'b0;
      stab_r      <= 1'b0;
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      tol_r       <= tol_nxt;
      slot_r      <= slot_nxt;
      filled_r    <= filled_nxt;
      stab_r      <= stab_nxt;
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r   <= rd_cnt_nxt;
    ovr_r      <= ovr_nxt;
    spread_r   <= spread_nxt;
    svld_r     <= svld_nxt;
    o_ovr_r    <= o_ovr_nxt;
    o_stab_r   <= o_stab_nxt;
    o_spread_r <= o_spread_nxt;
    o_svld_r   <= o_svld_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_over_threshold = o_ovr_r;
  assign out_stable         = o_stab_r;
  assign out_window_spread  = o_spread_r;
  assign out_spread_valid   = o_svld_r;

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor warm-up stability detector. Samples are
// fed through the valid/stall input with random idle cycles, results are
// drained with random stalls, and every result word is compared with a
// cycle-free model of the sample ring, the min/max scan, the sticky stable
// flag and the alarm comparison. Register settings change between phases
// while the unit is idle; the ring is kept unsettled until the last phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import swsd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic                over;
    logic                stable;
    logic [SAMPLE_W-1:0] spread;
    logic                spread_ok;
  } outcome_t;

  class warmup_tracker;
    logic [SAMPLE_W-1:0] threshold;
    logic [SAMPLE_W-1:0] tolerance;
    logic [SAMPLE_W-1:0] ring [WINDOW_LEN];
    int unsigned         slot;
    bit                  filled;
    bit                  settled;
    outcome_t            due_outcomes [$];
    int unsigned         faults;

    function new();
      threshold = GAS_THRESHOLD_RST;
      tolerance = STAB_TOL_RST;
      foreach (ring[i]) ring[i] = '0;
      slot    = 0;
      filled  = 0;
      settled = 0;
      faults  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] v);
      case (idx)
        REG_GAS_THRESHOLD: threshold = v;
        REG_STAB_TOL:      tolerance = v;
        default: ;
      endcase
    endfunction

    function logic [SAMPLE_W-1:0] span_of(logic [SAMPLE_W-1:0] w [WINDOW_LEN]);
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
      lo = w[0];
      hi = w[0];
      foreach (w[i]) begin
        if (w[i] < lo) lo = w[i];
        if (w[i] > hi) hi = w[i];
      end
      return hi - lo;
    endfunction

    function bit would_settle(logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] w [WINDOW_LEN];
      if (settled || (!filled && slot != WINDOW_LEN - 1)) return 0;
      w = ring;
      w[slot] = s;
      return span_of(w) <= tolerance;
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] s);
      outcome_t o;
      o = '0;
      if (!settled) begin
        ring[slot] = s;
        slot++;
        if (slot >= WINDOW_LEN) begin
          slot   = 0;
          filled = 1;
        end
        if (filled) begin
          o.spread    = span_of(ring);
          o.spread_ok = 1'b1;
          if (o.spread <= tolerance) settled = 1;
        end
      end
      o.over   = s > threshold;
      o.stable = settled;
      due_outcomes.push_back(o);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        faults++;
      end
    endfunction

    function void check_word(outcome_t got);
      outcome_t exp_o;
      if (due_outcomes.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h", $time, got);
        faults++;
        return;
      end
      exp_o = due_outcomes.pop_front();
      compare_field("over_threshold", exp_o.over, got.over);
      compare_field("stable", exp_o.stable, got.stable);
      compare_field("window_spread", exp_o.spread, got.spread);
      compare_field("spread_valid", exp_o.spread_ok, got.spread_ok);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  in_sample  = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic                 out_over_threshold;
  logic                 out_stable;
  logic [SAMPLE_W-1:0]  out_window_spread;
  logic                 out_spread_valid;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [SAMPLE_W-1:0]  cfg_data   = '0;

  warmup_tracker trk = new();
  int unsigned   sent_count = 0;
  bit            keep_open  = 1;
  bit            calm;

  assign calm = (sent_count >= 700) && (sent_count < 900);

  sensor_warmup_stability_detector_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_over_threshold (out_over_threshold),
    .out_stable         (out_stable),
    .out_window_spread  (out_window_spread),
    .out_spread_valid   (out_spread_valid),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      trk.check_word({out_over_threshold, out_stable, out_window_spread, out_spread_valid});
    out_stall <= !calm && ($urandom_range(0, 99) < 28);
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if (keep_open && trk.would_settle(s)) s = s ^ 12'h800;
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    trk.take_sample(s);
    sent_count++;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (trk.due_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(input logic [SAMPLE_W-1:0] thr, input logic [SAMPLE_W-1:0] tol);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [SAMPLE_W-1:0]  val [3];
    idx = '{REG_GAS_THRESHOLD, REG_STAB_TOL, ($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B)};
    val = '{thr, tol, SAMPLE_W'($urandom_range(0, 4095))};
    drain_all();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      trk.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_mix(input int count);
    int left;
    int len;
    int base;
    int width;
    int v;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 70) begin
        len   = $urandom_range(10, 25);
        if (len > left) len = left;
        base  = $urandom_range(0, 4095);
        width = trk.tolerance + $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
          v = base + $urandom_range(0, width);
          if (v > 4095) v = 4095;
          send_sample(SAMPLE_W'(v));
        end
        left -= len;
      end else begin
        case ($urandom_range(0, 5))
          0:       v = 0;
          1:       v = 4095;
          default: v = $urandom_range(0, 4095);
        endcase
        send_sample(SAMPLE_W'(v));
        left--;
      end
    end
  endtask

  initial begin
    int base;
    int warm_vals [10];
    warm_vals = '{0, 4095, 1500, 1501, 1499, 2048, 1, 4094, 2047, 1024};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the ring with extremes, then hold a spread one above tolerance
    foreach (warm_vals[i]) send_sample(SAMPLE_W'(warm_vals[i]));
    for (int i = 0; i < 10; i++) send_sample((i % 2) ? 12'd1016 : 12'd1000);

    write_regs(12'd0, 12'd0);
    run_mix(350);
    write_regs(12'd4095, 12'd1023);
    run_mix(350);
    write_regs(SAMPLE_W'($urandom_range(0, 4095)), SAMPLE_W'($urandom_range(0, 1023)));
    run_mix(350);
    write_regs(12'd1500, 12'd15);
    run_mix(300);

    // let the ring settle, with the last window exactly at tolerance
    write_regs(SAMPLE_W'($urandom_range(0, 4095)), 12'd40);
    keep_open = 0;
    base = $urandom_range(0, 4055);
    for (int i = 0; i < 10; i++) send_sample(SAMPLE_W'((i % 2) ? base + 40 : base));
    run_mix(290);
    write_regs(12'd4095, 12'd4095);
    run_mix(150);
    write_regs(12'd0, SAMPLE_W'($urandom_range(0, 4095)));
    run_mix(130);

    drain_all();
    if (trk.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
